[hdl/cda_pkg.sv]
// Package with the shared types, codes and month-length table for the date adder.
`timescale 1ns / 1ps

package cda_pkg;

	// Fields of one input item.
	typedef struct packed {
		logic [13:0]        start_year;
		logic [3:0]         start_month;
		logic [4:0]         start_day;
		logic signed [15:0] day_offset;
	} req_t;

	// Fields of one result item.
	typedef struct packed {
		logic [13:0] result_year;
		logic [3:0]  result_month;
		logic [4:0]  result_day;
		logic [1:0]  status;
	} res_t;

	// Status codes of a result.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_DATE = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;

	// Calendar limits.
	localparam logic [13:0] YEAR_MIN  = 14'd1;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_DEC = 4'd12;

	// Reciprocal of 100 scaled by 2**19, exact for years below 16384.
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAP0,
		ST_CHECK,
		ST_STEP,
		ST_LEAP,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       leap_upd;
		logic       step;
		logic       finish;
		logic [1:0] status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic valid;
		logic fits;
		logic oob;
		logic year_chg;
	} stat_t;

	// Length of a month; zero for a month code that means nothing.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

[hdl/cda_ctrl.sv]
// Controller state machine that sequences the month walk of the date adder.
`timescale 1ns / 1ps

module cda_ctrl import cda_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_LEAP0;
			end
			ST_LEAP0: state_nx = ST_CHECK;
			ST_CHECK: begin
				state_nx = stat.valid ? ST_STEP : ST_IDLE;
			end
			ST_STEP: begin
				if (stat.fits) begin
					state_nx = ST_FINISH;
				end else if (stat.oob) begin
					state_nx = ST_IDLE;
				end else if (stat.year_chg) begin
					state_nx = ST_LEAP;
				end
			end
			ST_LEAP:   state_nx = ST_STEP;
			ST_FINISH: state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.status = STAT_OK;
		case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_LEAP0: cmd.leap_upd = 1'b1;
			ST_CHECK: begin
				if (!stat.valid) begin
					cmd.finish = 1'b1;
					cmd.status = STAT_BAD_DATE;
				end
			end
			ST_STEP: begin
				if (!stat.fits && stat.oob) begin
					cmd.finish = 1'b1;
					cmd.status = STAT_RANGE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_LEAP:   cmd.leap_upd = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hdl/cda_dp.sv]
// Datapath of the date adder: date registers, leap-year unit, month step and result register.
`timescale 1ns / 1ps

module cda_dp import cda_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  done,
	output res_t  res
);

	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [15:0] rem_q;
	logic        back_q;
	logic        leap_q;
	logic [13:0] sy_q;
	logic [3:0]  sm_q;
	logic [4:0]  sd_q;
	res_t        res_q;
	logic        done_q;

	logic [26:0] prod;
	logic [7:0]  cent;
	logic [14:0] cent_x100;
	logic [14:0] r100;
	logic        leap_nx;
	logic [4:0]  mlen;
	logic [4:0]  room;
	logic [4:0]  prev_len;
	logic        fwd_fits;
	logic        bwd_fits;
	logic        at_first;
	logic        at_last;

	// Leap test of the current year: y/100 by reciprocal, then the 4/100/400 rules.
	assign prod      = year_q * RECIP_100;
	assign cent      = prod[RECIP_SHIFT +: 8];
	assign cent_x100 = {7'd0, cent} * 15'd100;
	assign r100      = {1'b0, year_q} - cent_x100;
	assign leap_nx   = (year_q[1:0] == 2'b00) && ((r100 != 15'd0) || (cent[1:0] == 2'b00));

	// Month lengths and the distance to the end of the month.
	assign mlen     = month_len(month_q, leap_q);
	assign prev_len = month_len(month_q - 4'd1, leap_q);
	assign room     = mlen - day_q;
	assign fwd_fits = (rem_q <= {11'd0, room});
	assign bwd_fits = (rem_q < {11'd0, day_q});
	assign at_first = (year_q == YEAR_MIN) && (month_q == MONTH_JAN);
	assign at_last  = (year_q == YEAR_MAX) && (month_q == MONTH_DEC);

	// Status for the controller.
	always_comb begin
		stat.valid = (year_q >= YEAR_MIN) && (year_q <= YEAR_MAX) &&
			(month_q >= MONTH_JAN) && (month_q <= MONTH_DEC) &&
			(day_q != 5'd0) && (day_q <= mlen);
		stat.fits     = back_q ? bwd_fits : fwd_fits;
		stat.oob      = back_q ? at_first : at_last;
		stat.year_chg = back_q ? (month_q == MONTH_JAN) : (month_q == MONTH_DEC);
	end

	// Working date registers and leap flag: load an item, then walk a month per step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= req.start_year;
			month_q <= req.start_month;
			day_q   <= req.start_day;
			sy_q    <= req.start_year;
			sm_q    <= req.start_month;
			sd_q    <= req.start_day;
			back_q  <= req.day_offset[15];
			rem_q   <= req.day_offset[15] ? (~req.day_offset + 16'sd1) : req.day_offset;
		end else if (cmd.step) begin
			if (stat.fits) begin
				day_q <= back_q ? (day_q - rem_q[4:0]) : (day_q + rem_q[4:0]);
				rem_q <= 16'd0;
			end else if (!back_q) begin
				rem_q <= rem_q - {11'd0, room} - 16'd1;
				day_q <= 5'd1;
				if (month_q == MONTH_DEC) begin
					month_q <= MONTH_JAN;
					year_q  <= year_q + 14'd1;
				end else begin
					month_q <= month_q + 4'd1;
				end
			end else begin
				rem_q <= rem_q - {11'd0, day_q};
				if (month_q == MONTH_JAN) begin
					month_q <= MONTH_DEC;
					year_q  <= year_q - 14'd1;
					day_q   <= 5'd31;
				end else begin
					month_q <= month_q - 4'd1;
					day_q   <= prev_len;
				end
			end
		end
		if (cmd.leap_upd) begin
			leap_q <= leap_nx;
		end
	end

	// Result register: the walked date when ok, the start date otherwise.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.status <= cmd.status;
			if (cmd.status == STAT_OK) begin
				res_q.result_year  <= year_q;
				res_q.result_month <= month_q;
				res_q.result_day   <= day_q;
			end else begin
				res_q.result_year  <= sy_q;
				res_q.result_month <= sm_q;
				res_q.result_day   <= sd_q;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[hdl/calendar_date_add_days_top.sv]
// Top level of the Gregorian date adder: controller, datapath and checks.
//
//   Channel   Ports              Handshake
//   -------   ----------------   ----------------------------------------
//   input     start, busy, req   item taken at an edge with start && !busy
//   result    done, res          res is valid for the one cycle done is high
//
// The time an item takes grows with the number of month ends and year ends crossed;
// the month-step loop sets it. A bad start date ends at the date check, with no walk.
// The result is registered: done rises in the cycle after the finish command, and
// busy falls in that same cycle. Reset is asynchronous and returns the controller
// to idle; the receiver cannot stall.
`timescale 1ns / 1ps

module calendar_date_add_days_top import cda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	cmd_t  cmd;
	stat_t stat;

	// Controller.
	cda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	cda_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.res    (res)
	);

	// A result strobe is never held: each item passes the idle, first leap and check states before any finish.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// The block only turns busy after an item was offered.
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// A good result carries an in-range year and month and a nonzero day.
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.status == STAT_OK)) |->
			((res.result_month >= MONTH_JAN) && (res.result_month <= MONTH_DEC) &&
			(res.result_day != 5'd0) && (res.result_year >= YEAR_MIN) &&
			(res.result_year <= YEAR_MAX)))
		else $error("ok result with an impossible date");

	// A result is never given while idle with no finish pending.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in work");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the Gregorian date adder: directed table, then random dates.
`timescale 1ns / 1ps

module tb;
	import cda_pkg::*;

	// Cycles without any accepted item or result before the run is declared hung.
	localparam int IDLE_LIMIT = 6000;
	localparam int MAX_ROWS   = 32;
	localparam int N_RANDOM   = 450;
	localparam int REQ_W      = $bits(req_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;

	calendar_date_add_days_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always #1 clk = ~clk;

	// Results still owed by the block, oldest first.
	res_t expected_dates[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_valid = 0;
	int n_bad = 0;
	int n_range = 0;
	int idle_cycles = 0;
	bit burst = 1'b0;

	// Directed rows; a row with a typed result bypasses the predictor.
	req_t dir_req[MAX_ROWS];
	bit   dir_known[MAX_ROWS];
	res_t dir_want[MAX_ROWS];
	int   n_rows = 0;

	function automatic bit is_leap_year(input int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int days_in_month(input int y, input int m);
		int len;
		case (m)
			2:             len = is_leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   len = 30;
			1, 3, 5, 7, 8, 10, 12: len = 31;
			default:       len = 0;
		endcase
		return len;
	endfunction

	// Days elapsed since 0001-01-01 for a valid date.
	function automatic int days_since_epoch(input int y, input int m, input int d);
		int p;
		int n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (int k = 1; k < m; k++)
			n += days_in_month(y, k);
		return n + d - 1;
	endfunction

	// Predicted result of shifting the start date by the signed offset.
	function automatic res_t shift_date(input req_t q);
		res_t o;
		int y;
		int m;
		int d;
		int n;
		o.result_year  = q.start_year;
		o.result_month = q.start_month;
		o.result_day   = q.start_day;
		o.status       = STAT_OK;
		y = q.start_year;
		m = q.start_month;
		d = q.start_day;
		if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
			o.status = STAT_BAD_DATE;
		end else begin
			n = days_since_epoch(y, m, d) + int'($signed(q.day_offset));
			if (n < 0 || n > days_since_epoch(9999, 12, 31)) begin
				o.status = STAT_RANGE;
			end else begin
				// Estimate the year from the mean year length, then settle it.
				y = (n * 400) / 146097 + 1;
				while (y < 9999 && days_since_epoch(y + 1, 1, 1) <= n)
					y++;
				while (days_since_epoch(y, 1, 1) > n)
					y--;
				n -= days_since_epoch(y, 1, 1);
				m = 1;
				while (n >= days_in_month(y, m)) begin
					n -= days_in_month(y, m);
					m++;
				end
				o.result_year  = 14'(y);
				o.result_month = 4'(m);
				o.result_day   = 5'(n + 1);
			end
		end
		return o;
	endfunction

	function automatic req_t make_req(input int y, input int m, input int d, input int off);
		req_t q;
		q.start_year  = 14'(y);
		q.start_month = 4'(m);
		q.start_day   = 5'(d);
		q.day_offset  = 16'(off);
		return q;
	endfunction

	function automatic res_t make_res(input int y, input int m, input int d,
			input logic [1:0] st);
		res_t o;
		o.result_year  = 14'(y);
		o.result_month = 4'(m);
		o.result_day   = 5'(d);
		o.status       = st;
		return o;
	endfunction

	// A valid date in the given years, biased to month starts and ends, with an offset in the given range.
	function automatic req_t rand_date(input int ylo, input int yhi, input int olo,
			input int ohi);
		int y;
		int m;
		int d;
		int sel;
		y = int'($urandom_range(yhi - ylo)) + ylo;
		m = int'($urandom_range(12, 1));
		sel = int'($urandom_range(3));
		if (sel == 0)
			d = 1;
		else if (sel == 1)
			d = days_in_month(y, m);
		else
			d = int'($urandom_range(days_in_month(y, m), 1));
		return make_req(y, m, d, int'($urandom_range(ohi - olo)) + olo);
	endfunction

	task automatic add_row(input req_t q, input bit known, input res_t want);
		dir_req[n_rows]   = q;
		dir_known[n_rows] = known;
		dir_want[n_rows]  = want;
		n_rows++;
	endtask

	// Present one item, hold it until the block is idle again, and queue its expected result.
	task automatic send_date(input req_t q, input res_t want);
		int gap;
		gap = burst ? 0 : int'($urandom_range(4));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_dates.push_back(want);
		n_sent++;
	endtask

	// Result checker: every strobe must match the oldest outstanding item.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_dates.size() == 0) begin
				$error("unexpected result %0d-%0d-%0d status %0d",
					res.result_year, res.result_month, res.result_day, res.status);
				n_errors++;
			end else begin
				want = expected_dates.pop_front();
				n_checked++;
				if (want.status == STAT_OK)
					n_valid++;
				else if (want.status == STAT_BAD_DATE)
					n_bad++;
				else
					n_range++;
				if (res.result_year !== want.result_year) begin
					$error("result_year: expected %0d, got %0d", want.result_year,
						res.result_year);
					n_errors++;
				end
				if (res.result_month !== want.result_month) begin
					$error("result_month: expected %0d, got %0d", want.result_month,
						res.result_month);
					n_errors++;
				end
				if (res.result_day !== want.result_day) begin
					$error("result_day: expected %0d, got %0d", want.result_day,
						res.result_day);
					n_errors++;
				end
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		req_t q;
		int sel;
		int y;

		// Directed rows: zero offset, bad start dates, range limits, boundary steps, long shifts.
		add_row(make_req(2000, 1, 1, 0), 1'b1, make_res(2000, 1, 1, STAT_OK));
		add_row(make_req(0, 1, 1, 5), 1'b1, make_res(0, 1, 1, STAT_BAD_DATE));
		add_row(make_req(16383, 15, 31, -1), 1'b1, make_res(16383, 15, 31, STAT_BAD_DATE));
		add_row(make_req(10000, 6, 10, 3), 1'b1, make_res(10000, 6, 10, STAT_BAD_DATE));
		add_row(make_req(2020, 0, 5, 1), 1'b1, make_res(2020, 0, 5, STAT_BAD_DATE));
		add_row(make_req(2020, 13, 5, 1), 1'b1, make_res(2020, 13, 5, STAT_BAD_DATE));
		add_row(make_req(2020, 5, 0, 1), 1'b1, make_res(2020, 5, 0, STAT_BAD_DATE));
		add_row(make_req(1900, 2, 29, 1), 1'b1, make_res(1900, 2, 29, STAT_BAD_DATE));
		add_row(make_req(2023, 2, 29, 1), 1'b1, make_res(2023, 2, 29, STAT_BAD_DATE));
		add_row(make_req(2023, 4, 31, 1), 1'b1, make_res(2023, 4, 31, STAT_BAD_DATE));
		add_row(make_req(1, 1, 1, -1), 1'b1, make_res(1, 1, 1, STAT_RANGE));
		add_row(make_req(9999, 12, 31, 1), 1'b1, make_res(9999, 12, 31, STAT_RANGE));
		add_row(make_req(1, 1, 1, -32768), 1'b1, make_res(1, 1, 1, STAT_RANGE));
		add_row(make_req(9999, 12, 31, 32767), 1'b1, make_res(9999, 12, 31, STAT_RANGE));
		add_row(make_req(9999, 12, 31, 0), 1'b1, make_res(9999, 12, 31, STAT_OK));
		add_row(make_req(2000, 2, 29, 1), 1'b1, make_res(2000, 3, 1, STAT_OK));
		add_row(make_req(1999, 12, 31, 1), 1'b1, make_res(2000, 1, 1, STAT_OK));
		add_row(make_req(2024, 3, 1, -1), 1'b1, make_res(2024, 2, 29, STAT_OK));
		add_row(make_req(2100, 3, 1, -1), 1'b1, make_res(2100, 2, 28, STAT_OK));
		add_row(make_req(2000, 1, 31, 1), 1'b1, make_res(2000, 2, 1, STAT_OK));
		add_row(make_req(1, 1, 1, 32767), 1'b0, '0);
		add_row(make_req(9999, 12, 31, -32768), 1'b0, '0);
		add_row(make_req(5000, 6, 15, -32768), 1'b0, '0);
		add_row(make_req(5000, 6, 15, 32767), 1'b0, '0);
		add_row(make_req(8191, 10, 30, 400), 1'b0, '0);

		// Reset once at the start, released on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < n_rows; i++)
			send_date(dir_req[i], dir_known[i] ? dir_want[i] : shift_date(dir_req[i]));

		// Random part: mostly short shifts, some long ones, range edges, leap Februaries and raw random items.
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(39) == 0)
				burst = !burst;
			sel = int'($urandom_range(99));
			if (sel < 50) begin
				q = rand_date(1, 9999, -400, 400);
			end else if (sel < 65) begin
				q = rand_date(1, 9999, -32768, 32767);
			end else if (sel < 72) begin
				q = rand_date(1, 120, -32768, 2000);
			end else if (sel < 79) begin
				q = rand_date(9880, 9999, -2000, 32767);
			end else if (sel < 90) begin
				y = 100 * int'($urandom_range(99, 16)) + int'($urandom_range(4));
				q = make_req(y, int'($urandom_range(3, 2)), 1, int'($urandom_range(140)) - 70);
				q.start_day = 5'(int'($urandom_range(days_in_month(y, q.start_month), 1)));
			end else begin
				q = req_t'(REQ_W'({$urandom, $urandom}));
			end
			send_date(q, shift_date(q));
		end
		start <= 1'b0;

		// Drain the outstanding results, then watch a little longer for strays.
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Shifted %0d dates and checked %0d results.", n_sent, n_checked);
		$display("Outcomes: %0d valid, %0d bad start dates, %0d out of range; %0d errors.",
			n_valid, n_bad, n_range, n_errors);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/cda_pkg.sv
hdl/cda_ctrl.sv
hdl/cda_dp.sv
hdl/calendar_date_add_days_top.sv
tb/sv/tb.sv
